/* src/polyphonic_adsr_voice_engine_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the polyphonic ADSR voice engine
// Assertions sample on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef POLYPHONIC_ADSR_VOICE_ENGINE_UNIT_DEFINES_SVH
`define POLYPHONIC_ADSR_VOICE_ENGINE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define PAVE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PAVE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PAVE_ASSERT(lbl, prop, msg)
`define PAVE_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* src/pave_pkg.sv */
// ----------------------------------------------------------------------------
// pave_pkg
// Types, codes and constants of the polyphonic ADSR voice engine.
// ----------------------------------------------------------------------------
package pave_pkg;

  localparam int VOICES_DEF       = 16;
  localparam int SINE_ENTRIES_DEF = 1024;

  localparam logic [15:0] LVL_ONE = 16'h8000;
  localparam logic [23:0] CNT_MAX = 24'hFF_FFFF;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_NOTE_ON  = 2'd1,
    CMD_NOTE_OFF = 2'd2,
    CMD_ALL_OFF  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_OSC_SHAPE     = 3'd0,
    REG_MASTER_VOLUME = 3'd1,
    REG_ATTACK_LEN    = 3'd2,
    REG_DECAY_LEN     = 3'd3,
    REG_SUSTAIN_LVL   = 3'd4,
    REG_RELEASE_LEN   = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SAW    = 2'd1,
    WAVE_SQUARE = 2'd2
  } osc_shape_e;

  typedef enum logic [2:0] {
    ST_OFF     = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } env_stage_e;

  typedef enum logic [3:0] {
    S_IDLE, S_NWR, S_VSEL, S_ENV, S_DIV, S_MUL1, S_LVL,
    S_OSC, S_ROM, S_MIX, S_ACC, S_SCALE, S_OUT
  } state_e;

  typedef struct packed {
    env_stage_e  stage;
    logic [23:0] cnt;
    logic [31:0] slope;
    logic [15:0] rl;
    logic [31:0] phase;
    logic [31:0] step;
  } voice_rec_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [23:0] den;
  } div_req_t;

  // Sine of phase p, Q1.15, Taylor series in Q30 (elaboration time only).
  function automatic logic signed [15:0] sine_of(input logic [31:0] p);
    logic [63:0] r, x, x2, term, v;
    logic signed [63:0] sum;
    r = {34'd0, p[29:0]};
    if (p[30]) r = 64'h4000_0000 - r;
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    sum  = signed'(x);
    term = ((x * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    if (sum < 0) sum = '0;
    v = (unsigned'(sum) + 64'd16384) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return p[31] ? -signed'(v[15:0]) : signed'(v[15:0]);
  endfunction

endpackage

/* src/pave_div.sv */
// ----------------------------------------------------------------------------
// pave_div
// Restoring divider, 32-bit dividend by 24-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module pave_div import pave_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  output logic        done_o,
  output logic [31:0] quo_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [23:0] rem_q, rem_d;
  logic [31:0] num_q, num_d;
  logic [23:0] den_q, den_d;
  logic [24:0] trial;
  logic        ge;

  always_comb begin
    trial  = {rem_q, num_q[31]};
    ge     = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      num_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      // shift in one dividend bit, keep the remainder below the divisor
      rem_d = ge ? 24'(trial - {1'b0, den_q}) : trial[23:0];
      num_d = {num_q[30:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

/* src/polyphonic_adsr_voice_engine_unit.sv */
// ----------------------------------------------------------------------------
// polyphonic_adsr_voice_engine_unit
// Polyphonic oscillator synth: per-voice phase accumulator and ADSR envelope,
// mixed through one shared multiplier under a sequencer.
// ----------------------------------------------------------------------------
// Channel   Signals                      Contents (low bit up)
// s_axis    tvalid/tready/tdata/tuser    tdata: voice[3:0], phase_step[35:4]
//                                        tuser: command[1:0]
// m_axis    tvalid/tready/tdata          tdata: sample[15:0] (tick only)
// cfg       cfg_we_i/cfg_idx_i/cfg_data_i register write, no read-back
//
// Note on / note off read and rewrite the voice record; all notes off acts in
// idle. A tick visits every voice slot in turn; each voice that sounds runs the
// envelope, level, oscillator, rom, mix and accumulate steps (a voice that falls
// silent leaves early), a voice that starts a segment waits on the bit-serial
// slope divider, and one multiplier serves envelope, oscillator, mix and volume.
// Reset clears voice activity and record valid bits at once; no sweep.
// The input side is ready only when idle; a held output stalls the next tick.
// ----------------------------------------------------------------------------
`include "polyphonic_adsr_voice_engine_unit_defines.svh"

module polyphonic_adsr_voice_engine_unit import pave_pkg::*; #(
  parameter int VOICES       = VOICES_DEF,
  parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // voice[3:0], phase_step[35:4]
  input  logic [1:0]  s_axis_tuser_i,   // command[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // sample[15:0]
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int IW    = $clog2(VOICES + 1);
  localparam int TW    = $clog2(SINE_ENTRIES);
  localparam int ACC_W = 32 + VW;
  localparam int PW    = ACC_W + 25;

  typedef logic signed [15:0] sine_tab_t [SINE_ENTRIES];

  function automatic sine_tab_t build_tab();
    sine_tab_t   t;
    logic [63:0] p;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      p    = (64'(i) << 32) / SINE_ENTRIES;
      t[i] = sine_of(p[31:0]);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_tab();

  // configuration
  logic [1:0]  shape_q;
  logic [15:0] vol_q, sus_q;
  logic [23:0] atk_q, dec_q, rel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= WAVE_SINE;
      vol_q   <= 16'd32768;
      atk_q   <= 24'd480;
      dec_q   <= 24'd480;
      sus_q   <= 16'd16384;
      rel_q   <= 24'd480;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_OSC_SHAPE:     shape_q <= cfg_data_i[1:0];
        REG_MASTER_VOLUME: vol_q   <= cfg_data_i[15:0];
        REG_ATTACK_LEN:    atk_q   <= cfg_data_i;
        REG_DECAY_LEN:     dec_q   <= cfg_data_i;
        REG_SUSTAIN_LVL:   sus_q   <= cfg_data_i[15:0];
        REG_RELEASE_LEN:   rel_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control and working registers
  state_e                    state_q, state_d;
  logic [VOICES-1:0]         on_q, on_d, vld_q, vld_d;
  logic [IW-1:0]             idx_q, idx_d;
  logic [1:0]                cmd_q, cmd_d;
  logic [VW-1:0]             vsel_q, vsel_d;
  logic [31:0]               step_q, step_d;
  voice_rec_t                w_q, w_d;
  logic                      adv_q, adv_d;
  logic [15:0]               lvl_q, lvl_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic                      mv_q, mv_d;
  logic [15:0]               md_q, md_d;

  // voice record memory
  voice_rec_t                vmem_q [VOICES];
  voice_rec_t                rd_q, mem_wd;
  logic                      rdv_q;
  logic                      mem_we, mem_re;
  logic [VW-1:0]             mem_wa, mem_ra;

  // shared multiplier and sine rom
  logic signed [ACC_W-1:0]   mul_a;
  logic signed [24:0]        mul_b;
  logic signed [PW-1:0]      mul_q;
  logic                      mul_en, rom_en;
  logic signed [15:0]        rom_q;

  div_req_t                  div_req;
  logic                      div_done;
  logic [31:0]               div_quo;

  // combinational helpers
  voice_rec_t                rec;
  logic [23:0]               cnt_inc, len, lenx;
  logic [15:0]               s_lvl, rlc;
  logic [39:0]               drop;
  logic [40:0]               atk_sum;
  logic signed [16:0]        osc;
  logic signed [PW-1:0]      scaled;
  logic signed [PW-31:0]     smp;
  logic                      in_acc, out_acc;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    rec = rd_q;
    if (!rdv_q) begin
      rec.rl    = '0;
      rec.phase = '0;
    end
    s_lvl   = (sus_q > LVL_ONE) ? LVL_ONE : sus_q;
    rlc     = (rec.rl > LVL_ONE) ? LVL_ONE : rec.rl;
    cnt_inc = (rec.cnt != CNT_MAX) ? rec.cnt + 24'd1 : rec.cnt;
    case (rec.stage)
      ST_ATTACK:  len = atk_q;
      ST_DECAY:   len = dec_q;
      default:    len = rel_q;
    endcase
    lenx    = (len == '0) ? 24'd1 : len;
    drop    = mul_q[55:16];
    atk_sum = 41'(w_q.rl > LVL_ONE ? LVL_ONE : w_q.rl) + 41'(drop);
    case (osc_shape_e'(shape_q))
      WAVE_SAW:    osc = $signed({1'b0, w_q.phase[31:16]}) - 17'sd32768;
      WAVE_SQUARE: osc = (w_q.phase != '0 && !w_q.phase[31]) ? 17'sd32767 : -17'sd32767;
      default:     osc = 17'(rom_q);
    endcase
    scaled = (mul_q < 0) ? mul_q + PW'(32'h3FFF_FFFF) : mul_q;
    smp    = scaled[PW-1:30];
  end

  always_comb begin
    state_d = state_q;
    on_d    = on_q;
    vld_d   = vld_q;
    idx_d   = idx_q;
    cmd_d   = cmd_q;
    vsel_d  = vsel_q;
    step_d  = step_q;
    w_d     = w_q;
    adv_d   = adv_q;
    lvl_d   = lvl_q;
    acc_d   = acc_q;
    mv_d    = mv_q && !m_axis_tready_i;
    md_d    = md_q;
    mem_we  = 1'b0;
    mem_wa  = idx_q[VW-1:0];
    mem_wd  = w_q;
    mem_re  = 1'b0;
    mem_ra  = idx_q[VW-1:0];
    mul_en  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    rom_en  = 1'b0;
    div_req = '{start: 1'b0, num: '0, den: lenx};

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d  = s_axis_tuser_i;
          vsel_d = VW'(s_axis_tdata_i[3:0]);
          step_d = s_axis_tdata_i[35:4];
          case (cmd_e'(s_axis_tuser_i))
            CMD_TICK: begin
              idx_d   = '0;
              acc_d   = '0;
              state_d = S_VSEL;
            end
            CMD_ALL_OFF: on_d = '0;
            default: begin
              if (int'(s_axis_tdata_i[3:0]) < VOICES) begin
                mem_re  = 1'b1;
                mem_ra  = VW'(s_axis_tdata_i[3:0]);
                state_d = S_NWR;
              end
            end
          endcase
        end
      end
      S_NWR: begin
        mem_wd       = rec;
        mem_wd.cnt   = '0;
        mem_wd.slope = '0;
        if (cmd_e'(cmd_q) == CMD_NOTE_ON) begin
          mem_wd.stage = ST_ATTACK;
          mem_wd.step  = step_q;
          on_d[vsel_q] = 1'b1;
        end else begin
          mem_wd.stage = ST_RELEASE;
        end
        mem_we        = 1'b1;
        mem_wa        = vsel_q;
        vld_d[vsel_q] = 1'b1;
        state_d       = S_IDLE;
      end
      S_VSEL: begin
        if (int'(idx_q) == VOICES) begin
          state_d = S_SCALE;
        end else if (on_q[idx_q[VW-1:0]]) begin
          mem_re  = 1'b1;
          state_d = S_ENV;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      S_ENV: begin
        w_d     = rec;
        w_d.cnt = cnt_inc;
        adv_d   = cnt_inc >= lenx;
        if (rec.stage != ST_ATTACK && rec.stage != ST_DECAY &&
            rec.stage != ST_SUSTAIN && rec.stage != ST_RELEASE) begin
          // stage off: level zero, drop the voice
          mem_we                  = 1'b1;
          mem_wd                  = w_d;
          on_d[idx_q[VW-1:0]]     = 1'b0;
          idx_d                   = idx_q + IW'(1);
          state_d                 = S_VSEL;
        end else if (rec.stage == ST_RELEASE && cnt_inc >= lenx) begin
          mem_we                  = 1'b1;
          mem_wd                  = w_d;
          mem_wd.stage            = ST_OFF;
          mem_wd.cnt              = '0;
          mem_wd.slope            = '0;
          on_d[idx_q[VW-1:0]]     = 1'b0;
          idx_d                   = idx_q + IW'(1);
          state_d                 = S_VSEL;
        end else if (cnt_inc == 24'd1 && rec.stage != ST_SUSTAIN) begin
          // first sample of a segment: compute the slope
          div_req.start = 1'b1;
          case (rec.stage)
            ST_ATTACK: div_req.num = (32'(LVL_ONE) - 32'(rlc)) << 16;
            ST_DECAY:  div_req.num = (32'(LVL_ONE) - 32'(s_lvl)) << 16;
            default:   div_req.num = 32'(s_lvl) << 16;
          endcase
          state_d = S_DIV;
        end else begin
          state_d = S_MUL1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          w_d.slope = div_quo;
          state_d   = S_MUL1;
        end
      end
      S_MUL1: begin
        mul_en  = 1'b1;
        mul_a   = ACC_W'(w_q.slope);
        mul_b   = 25'(w_q.cnt);
        state_d = S_LVL;
      end
      S_LVL: begin
        case (w_q.stage)
          ST_ATTACK: lvl_d = (atk_sum > 41'(LVL_ONE)) ? LVL_ONE : atk_sum[15:0];
          ST_DECAY:  lvl_d = (drop >= 40'(LVL_ONE)) ? 16'd0 : LVL_ONE - drop[15:0];
          ST_SUSTAIN: lvl_d = s_lvl;
          default: begin
            lvl_d    = (drop >= 40'(s_lvl)) ? 16'd0 : s_lvl - drop[15:0];
            w_d.rl   = lvl_d;
          end
        endcase
        if (adv_q && (w_q.stage == ST_ATTACK || w_q.stage == ST_DECAY)) begin
          w_d.cnt   = '0;
          w_d.slope = '0;
          w_d.stage = (w_q.stage == ST_ATTACK) ? ST_DECAY : ST_SUSTAIN;
        end
        if (lvl_d == '0) begin
          mem_we              = 1'b1;
          mem_wd              = w_d;
          on_d[idx_q[VW-1:0]] = 1'b0;
          idx_d               = idx_q + IW'(1);
          state_d             = S_VSEL;
        end else begin
          state_d = S_OSC;
        end
      end
      S_OSC: begin
        mul_en  = 1'b1;
        mul_a   = ACC_W'(w_q.phase);
        mul_b   = 25'(SINE_ENTRIES);
        state_d = S_ROM;
      end
      S_ROM: begin
        rom_en  = 1'b1;
        state_d = S_MIX;
      end
      S_MIX: begin
        mul_en  = 1'b1;
        mul_a   = ACC_W'(osc);
        mul_b   = 25'(lvl_q);
        state_d = S_ACC;
      end
      S_ACC: begin
        acc_d        = acc_q + mul_q[ACC_W-1:0];
        mem_we       = 1'b1;
        mem_wd       = w_q;
        mem_wd.phase = w_q.phase + w_q.step;
        idx_d        = idx_q + IW'(1);
        state_d      = S_VSEL;
      end
      S_SCALE: begin
        mul_en  = 1'b1;
        mul_a   = acc_q;
        mul_b   = 25'(vol_q);
        state_d = S_OUT;
      end
      S_OUT: begin
        // hold until the previous sample is taken
        if (!mv_q || m_axis_tready_i) begin
          mv_d    = 1'b1;
          if (smp > 32767)       md_d = 16'h7FFF;
          else if (smp < -32768) md_d = 16'h8000;
          else                   md_d = smp[15:0];
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      on_q    <= '0;
      vld_q   <= '0;
      idx_q   <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      on_q    <= on_d;
      vld_q   <= vld_d;
      idx_q   <= idx_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    vsel_q <= vsel_d;
    step_q <= step_d;
    w_q    <= w_d;
    adv_q  <= adv_d;
    lvl_q  <= lvl_d;
    acc_q  <= acc_d;
    md_q   <= md_d;
    if (mul_en) mul_q <= mul_a * mul_b;
    if (rom_en) rom_q <= SINE_TAB[mul_q[32 +: TW]];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) vmem_q[mem_wa] <= mem_wd;
    if (mem_re) begin
      rd_q  <= vmem_q[mem_ra];
      rdv_q <= vld_q[mem_ra];
    end
  end

  pave_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = md_q;

  `PAVE_ASSERT_NEVER(a_div_done_state, div_done && state_q != S_DIV, "divider done outside slope wait")
  `PAVE_ASSERT(a_tick_busy, in_acc && s_axis_tuser_i == CMD_TICK |=> !s_axis_tready_o, "tick did not hold input")
  `PAVE_ASSERT(a_out_src, $rose(m_axis_tvalid_o) |-> $past(state_q) == S_OUT, "sample raised outside output step")
  `PAVE_ASSERT_NEVER(a_mem_clash, mem_we && mem_re, "voice record read and written together")

endmodule

/* bench/pave_sample_checker.sv */
// ----------------------------------------------------------------------------
// pave_sample_checker
// Watches the command, sample and register-write channels of the voice
// engine. It keeps its own copy of every voice and register, works out the
// sample that each accepted tick must produce and compares it with the
// sample that comes out.
// ----------------------------------------------------------------------------
module pave_sample_checker import pave_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [39:0] s_axis_tdata_i,   // voice[3:0], phase_step[35:4]
  input  logic [1:0]  s_axis_tuser_i,   // command[1:0]
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,   // sample[15:0]
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o,
  output int          commands_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = 16;
  localparam int ROM_N = 1024;

  logic signed [15:0] wave_rom [ROM_N];

  logic [1:0]  shape;
  logic [15:0] volume;
  logic [23:0] att_len, dec_len, rel_len;
  logic [15:0] sus_lvl;

  logic        active  [NV];
  env_stage_e  stage   [NV];
  logic [23:0] seg_cnt [NV];
  logic [31:0] slope   [NV];
  logic [15:0] rel_lvl [NV];
  logic [31:0] phase   [NV];
  logic [31:0] pstep   [NV];

  logic signed [15:0] expected_samples [$];
  int errors, checked, commands;

  // Quarter-wave Taylor series in Q30, rounded to Q1.15.
  function automatic logic signed [15:0] taylor_sine(input logic [31:0] p);
    longint unsigned r, x, x2, term, v;
    longint sum;
    r = {34'd0, p[29:0]};
    if (p[30]) r = 64'h4000_0000 - r;
    x = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    sum = longint'(x);
    term = x;
    for (int k = 1; k <= 5; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    v = (longint'(sum) + 16384) >> 15;
    if (v > 32767) v = 32767;
    return p[31] ? -signed'(v[15:0]) : signed'(v[15:0]);
  endfunction

  initial begin
    for (int i = 0; i < ROM_N; i++) wave_rom[i] = taylor_sine(32'(i) << 22);
  end

  function automatic int wave_value(input logic [31:0] p);
    if (shape == WAVE_SAW) return int'({16'd0, p[31:16]}) - 32768;
    if (shape == WAVE_SQUARE) return (p != 0 && !p[31]) ? 32767 : -32767;
    return int'(wave_rom[p[31:22]]);
  endfunction

  function automatic int unsigned len_or_one(input logic [23:0] l);
    return (l == 0) ? 1 : int'(l);
  endfunction

  // Advance the envelope of voice v by one sample and return its level.
  function automatic int unsigned next_env_level(input int v);
    int unsigned c, s, lvl, len, rl;
    longint unsigned drop;
    bit adv;
    s = (sus_lvl > LVL_ONE) ? 32768 : sus_lvl;
    adv = 0;
    lvl = 0;
    if (seg_cnt[v] != CNT_MAX) seg_cnt[v] = seg_cnt[v] + 1;
    c = seg_cnt[v];
    case (stage[v])
      ST_ATTACK: begin
        rl = (rel_lvl[v] > LVL_ONE) ? 32768 : rel_lvl[v];
        len = len_or_one(att_len);
        if (c >= len) adv = 1;
        if (c == 1) slope[v] = ((32768 - rl) << 16) / len;
        drop = (longint'(slope[v]) * c) >> 16;
        lvl = (rl + drop > 32768) ? 32768 : rl + int'(drop);
      end
      ST_DECAY: begin
        len = len_or_one(dec_len);
        if (c >= len) adv = 1;
        if (c == 1) slope[v] = ((32768 - s) << 16) / len;
        drop = (longint'(slope[v]) * c) >> 16;
        lvl = (drop >= 32768) ? 0 : 32768 - int'(drop);
      end
      ST_SUSTAIN: lvl = s;
      ST_RELEASE: begin
        len = len_or_one(rel_len);
        if (c >= len) begin
          stage[v] = ST_OFF;
          seg_cnt[v] = 0;
          slope[v] = 0;
          return 0;
        end
        if (c == 1) slope[v] = (s << 16) / len;
        drop = (longint'(slope[v]) * c) >> 16;
        lvl = (drop >= s) ? 0 : s - int'(drop);
        rel_lvl[v] = lvl[15:0];
      end
      default: return 0;
    endcase
    if (adv) begin
      seg_cnt[v] = 0;
      slope[v] = 0;
      stage[v] = env_stage_e'(stage[v] + 3'd1);
    end
    return lvl;
  endfunction

  function automatic logic signed [15:0] mix_tick();
    longint acc, smp;
    int unsigned lvl;
    acc = 0;
    for (int i = 0; i < NV; i++) begin
      if (!active[i]) continue;
      lvl = next_env_level(i);
      if (lvl == 0) begin
        active[i] = 0;
        continue;
      end
      acc += longint'(wave_value(phase[i])) * longint'(lvl);
      phase[i] = phase[i] + pstep[i];
    end
    smp = (acc * longint'({16'd0, volume})) / 64'sd1073741824;
    if (smp > 32767) smp = 32767;
    if (smp < -32768) smp = -32768;
    return smp[15:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [3:0] v;
    logic signed [15:0] want;
    if (!rst_ni) begin
      shape = WAVE_SINE;
      volume = 16'd32768;
      att_len = 24'd480;
      dec_len = 24'd480;
      sus_lvl = 16'd16384;
      rel_len = 24'd480;
      for (int i = 0; i < NV; i++) begin
        active[i] = 0;
        stage[i] = ST_OFF;
        seg_cnt[i] = 0;
        slope[i] = 0;
        rel_lvl[i] = 0;
        phase[i] = 0;
        pstep[i] = 0;
      end
      expected_samples.delete();
      errors = 0;
      checked = 0;
      commands = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample, expected none actual %0d", $time,
                   $signed(m_axis_tdata_i));
          errors++;
        end else begin
          want = expected_samples.pop_front();
          checked++;
          if (want !== $signed(m_axis_tdata_i)) begin
            $display("%0t: sample mismatch, expected %0d actual %0d", $time, want,
                     $signed(m_axis_tdata_i));
            errors++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        v = s_axis_tdata_i[3:0];
        commands++;
        case (cmd_e'(s_axis_tuser_i))
          CMD_NOTE_ON: begin
            stage[v] = ST_ATTACK;
            seg_cnt[v] = 0;
            slope[v] = 0;
            active[v] = 1;
            pstep[v] = s_axis_tdata_i[35:4];
          end
          CMD_NOTE_OFF: begin
            stage[v] = ST_RELEASE;
            seg_cnt[v] = 0;
            slope[v] = 0;
          end
          CMD_ALL_OFF: for (int i = 0; i < NV; i++) active[i] = 0;
          default: expected_samples.push_back(mix_tick());
        endcase
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_OSC_SHAPE:     shape = cfg_data_i[1:0];
          REG_MASTER_VOLUME: volume = cfg_data_i[15:0];
          REG_ATTACK_LEN:    att_len = cfg_data_i;
          REG_DECAY_LEN:     dec_len = cfg_data_i;
          REG_SUSTAIN_LVL:   sus_lvl = cfg_data_i[15:0];
          REG_RELEASE_LEN:   rel_len = cfg_data_i;
          default: ;
        endcase
      end
    end
    errors_o <= errors;
    pending_o <= expected_samples.size();
    checked_o <= checked;
    commands_o <= commands;
  end

endmodule

/* bench/tb_polyphonic_adsr_voice_engine_unit.sv */
// ----------------------------------------------------------------------------
// tb_polyphonic_adsr_voice_engine_unit
// Drives note and tick commands into the voice engine under several register
// settings with random idling on both channels; the sample checker predicts
// and compares every output sample.
// ----------------------------------------------------------------------------
module tb_polyphonic_adsr_voice_engine_unit import pave_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 190;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = CMD_TICK;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = REG_OSC_SHAPE;
  logic [23:0] cfg_data_i = '0;

  int errors, pending, checked, commands;
  bit no_idle = 0;
  int settings = 0;

  always #1 clk_i = ~clk_i;

  polyphonic_adsr_voice_engine_unit u_top (.*);

  pave_sample_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .checked_o(checked), .commands_o(commands)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_cmd(input cmd_e cmd, input logic [3:0] v, input logic [31:0] st);
    int g;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= cmd;
    s_axis_tdata_i <= {4'd0, st, v};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    g = idle_len();
    if (g > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Let every expected sample arrive and the last note command settle.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [1:0] shp, input logic [15:0] vol,
                            input logic [23:0] al, input logic [23:0] dl,
                            input logic [15:0] sl, input logic [23:0] rl);
    logic [23:0] vals [6];
    vals = '{{22'd0, shp}, {8'd0, vol}, al, dl, {8'd0, sl}, rl};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 3'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings++;
  endtask

  task automatic random_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 66) send_cmd(CMD_TICK, 4'($urandom), 32'($urandom));
    else if (r < 84) send_cmd(CMD_NOTE_ON, 4'($urandom), 32'($urandom));
    else if (r < 96) send_cmd(CMD_NOTE_OFF, 4'($urandom), 32'($urandom));
    else send_cmd(CMD_ALL_OFF, 4'($urandom), 32'($urandom));
  endtask

  // Receiver: random stalls, one long hold-off to back the block up.
  initial begin
    int rx, g;
    bit held;
    rx = 0;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) rx++;
      if (rx == 40 && !held) begin
        held = 1;
        m_axis_tready_i <= 1'b0;
        repeat (3000) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else begin
        g = idle_len();
        if (g == 0) m_axis_tready_i <= 1'b1;
        else begin
          m_axis_tready_i <= 1'b0;
          repeat (g) @(posedge clk_i);
          m_axis_tready_i <= 1'b1;
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset register values.
    send_cmd(CMD_TICK, 4'd0, 32'd0);
    send_cmd(CMD_NOTE_ON, 4'd0, 32'd0);
    send_cmd(CMD_NOTE_ON, 4'd15, 32'hFFFF_FFFF);
    repeat (3) send_cmd(CMD_TICK, 4'd0, 32'd0);
    send_cmd(CMD_NOTE_OFF, 4'd0, 32'd0);
    send_cmd(CMD_TICK, 4'd15, 32'hFFFF_FFFF);
    send_cmd(CMD_ALL_OFF, 4'd15, 32'hFFFF_FFFF);
    send_cmd(CMD_TICK, 4'd0, 32'd0);
    send_cmd(CMD_NOTE_ON, 4'd7, 32'h5555_5555);
    send_cmd(CMD_NOTE_ON, 4'd8, 32'hAAAA_AAAA);
    send_cmd(CMD_TICK, 4'd0, 32'd0);
    send_cmd(CMD_NOTE_ON, 4'd7, 32'h0100_0000);
    send_cmd(CMD_TICK, 4'd0, 32'd0);
    send_cmd(CMD_NOTE_OFF, 4'd8, 32'd0);
    send_cmd(CMD_NOTE_OFF, 4'd3, 32'd0);
    send_cmd(CMD_TICK, 4'd0, 32'd0);
    send_cmd(CMD_ALL_OFF, 4'd0, 32'd0);
    send_cmd(CMD_TICK, 4'd0, 32'd0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: write_regs(WAVE_SINE, 16'd32768, 24'd4, 24'd6, 16'd16384, 24'd8);
        1: write_regs(WAVE_SAW, 16'hFFFF, 24'd1, 24'd1, 16'd32768, 24'd3);
        2: write_regs(WAVE_SQUARE, 16'd0, 24'd0, 24'd0, 16'hFFFF, 24'd0);
        3: write_regs(2'd3, 16'd1, 24'hFF_FFFF, 24'd5, 16'd0, 24'hFF_FFFF);
        4: write_regs(WAVE_SINE, 16'($urandom_range(20000, 65535)), 24'd20, 24'd30,
                      16'd100, 24'd40);
        default: write_regs(WAVE_SAW, 16'd40000, 24'd2, 24'd3, 16'd20000, 24'd5);
      endcase
      no_idle = (ph == 1);
      repeat (ITEMS_PER_PHASE) random_cmd();
      drain();
    end

    // Allow stray samples to show.
    repeat (800) @(posedge clk_i);
    $display("Covered %0d commands and %0d compared samples", commands, checked);
    $display("over %0d register settings, all waveforms and envelope stages", settings);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/pave_pkg.sv
src/pave_div.sv
src/polyphonic_adsr_voice_engine_unit.sv
bench/pave_sample_checker.sv
bench/tb_polyphonic_adsr_voice_engine_unit.sv
